// ----- rtl/core/servo_command_parser_defines.svh -----
// Assertion macros for the servo command parser.
`ifndef SERVO_COMMAND_PARSER_DEFINES_SVH
`define SERVO_COMMAND_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SCP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scp assertion failed");

// Next-cycle implication, checked out of reset.
`define SCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scp assertion failed");

`endif

// ----- rtl/core/scp_pkg.sv -----
package scp_pkg;

  localparam logic [7:0] ANGLE_MAX    = 8'd180;
  localparam logic [7:0] ANGLE_CENTER = 8'd90;
  localparam logic [7:0] BYTE_CR      = 8'd13;
  localparam logic [7:0] BYTE_LF      = 8'd10;
  localparam logic [7:0] BYTE_SPACE   = 8'd32;
  localparam logic [2:0] CENTER_LEN   = 3'd6;
  localparam logic [2:0] SWEEP_LEN    = 3'd5;
  localparam logic [2:0] COUNT_SAT    = 3'd7;
  localparam logic [7:0] NUMBER_SAT   = 8'd255;

  typedef enum logic [1:0] {
    ACT_UNKNOWN = 2'd0,
    ACT_MOVE    = 2'd1,
    ACT_SWEEP   = 2'd2
  } action_t;

  typedef struct packed {
    logic [2:0] byte_count;
    logic [7:0] first_value;
    logic [2:0] center_progress;
    logic [2:0] sweep_progress;
    logic       center_alive;
    logic       sweep_alive;
    logic       digits_alive;
    logic       digit_count;
    logic [7:0] number_value;
    logic       trailing_space;
  } msg_state_t;

  localparam msg_state_t MSG_CLEAR = '{
    byte_count:      3'd0,
    first_value:     8'd0,
    center_progress: 3'd0,
    sweep_progress:  3'd0,
    center_alive:    1'b1,
    sweep_alive:     1'b1,
    digits_alive:    1'b1,
    digit_count:     1'b0,
    number_value:    8'd0,
    trailing_space:  1'b0
  };

  typedef struct packed {
    action_t    action;
    logic [7:0] angle;
  } result_t;

  function automatic logic [7:0] center_letter(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = "C";
      3'd1:    c = "E";
      3'd2:    c = "N";
      3'd3:    c = "T";
      3'd4:    c = "E";
      3'd5:    c = "R";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] sweep_letter(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = "S";
      3'd1:    c = "W";
      3'd2:    c = "E";
      3'd3:    c = "E";
      3'd4:    c = "P";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    if ((b >= "a") && (b <= "z")) begin
      return b - 8'd32;
    end
    return b;
  endfunction

endpackage

// ----- rtl/core/scp_parse.sv -----
module scp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       data,
  input  logic             last,
  output scp_pkg::result_t result
);

  scp_pkg::msg_state_t st;
  scp_pkg::msg_state_t st_next;
  logic [7:0]          current_angle;
  logic [7:0]          current_angle_next;
  logic [7:0]          upper_byte;
  logic                is_ws;
  logic [11:0]         number_acc;

  always_comb begin
    upper_byte = scp_pkg::to_upper(data);
    is_ws      = (data == scp_pkg::BYTE_CR) || (data == scp_pkg::BYTE_LF) ||
                 (data == scp_pkg::BYTE_SPACE);
    number_acc = {4'd0, st.number_value} * 12'd10 + {8'd0, data[3:0]};

    st_next = st;
    if (st.byte_count == 3'd0) begin
      st_next.first_value = data;
    end
    if (st.byte_count != scp_pkg::COUNT_SAT) begin
      st_next.byte_count = st.byte_count + 3'd1;
    end

    if (is_ws) begin
      st_next.trailing_space = 1'b1;
    end else if (st.trailing_space) begin
      st_next.center_alive = 1'b0;
      st_next.sweep_alive  = 1'b0;
      st_next.digits_alive = 1'b0;
    end else begin
      if (st.center_alive && (st.center_progress < scp_pkg::CENTER_LEN) &&
          (upper_byte == scp_pkg::center_letter(st.center_progress))) begin
        st_next.center_progress = st.center_progress + 3'd1;
      end else begin
        st_next.center_alive = 1'b0;
      end
      if (st.sweep_alive && (st.sweep_progress < scp_pkg::SWEEP_LEN) &&
          (upper_byte == scp_pkg::sweep_letter(st.sweep_progress))) begin
        st_next.sweep_progress = st.sweep_progress + 3'd1;
      end else begin
        st_next.sweep_alive = 1'b0;
      end
      if (st.digits_alive && scp_pkg::is_digit(data)) begin
        st_next.number_value = (number_acc > {4'd0, scp_pkg::NUMBER_SAT}) ?
                               scp_pkg::NUMBER_SAT : number_acc[7:0];
        st_next.digit_count  = 1'b1;
      end else begin
        st_next.digits_alive = 1'b0;
      end
    end

    result.action = scp_pkg::ACT_UNKNOWN;
    result.angle  = current_angle;
    priority if ((st_next.byte_count == 3'd1) &&
                 (st_next.first_value <= scp_pkg::ANGLE_MAX) &&
                 !scp_pkg::is_digit(st_next.first_value)) begin
      result.action = scp_pkg::ACT_MOVE;
      result.angle  = st_next.first_value;
    end else if (st_next.center_alive &&
                 (st_next.center_progress == scp_pkg::CENTER_LEN)) begin
      result.action = scp_pkg::ACT_MOVE;
      result.angle  = scp_pkg::ANGLE_CENTER;
    end else if (st_next.sweep_alive &&
                 (st_next.sweep_progress == scp_pkg::SWEEP_LEN)) begin
      result.action = scp_pkg::ACT_SWEEP;
      result.angle  = scp_pkg::ANGLE_CENTER;
    end else if (st_next.digits_alive && st_next.digit_count) begin
      result.action = scp_pkg::ACT_MOVE;
      result.angle  = (st_next.number_value > scp_pkg::ANGLE_MAX) ?
                      scp_pkg::ANGLE_MAX : st_next.number_value;
    end else begin
      result.action = scp_pkg::ACT_UNKNOWN;
      result.angle  = current_angle;
    end

    current_angle_next = (advance && last) ? result.angle : current_angle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= scp_pkg::MSG_CLEAR;
      current_angle <= scp_pkg::ANGLE_CENTER;
    end else if (advance) begin
      st            <= last ? scp_pkg::MSG_CLEAR : st_next;
      current_angle <= current_angle_next;
    end
  end

endmodule

// ----- rtl/core/servo_command_parser.sv -----
// Servo command parser.
// Input channel (msg_valid / msg_stall): one message byte per transfer on
// msg_byte, with last_byte high on the final byte of a message.
// Output channel (cmd_valid / cmd_stall): one result per message, carrying
// action (unknown, move, sweep) and the servo angle after the command.
// Throughput: one byte per cycle, sustained while no last byte waits on a stalled result.
// Path: the last byte of a message goes into the input register, then its
// result into the result register that drives the outputs; a stalled
// previous result can hold that byte in the input register in between.
// Bytes that are not last never wait on the output side; a last byte holds
// in the input register while a previous result is stalled, and msg_stall
// rises only then.
// Reset clears the partial message, both valid flags, and sets the angle
// to 90 degrees.
// A stalled result holds its value until cmd_stall drops.
`include "servo_command_parser_defines.svh"

module servo_command_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       msg_valid,
  output logic       msg_stall,
  input  logic [7:0] msg_byte,
  input  logic       last_byte,
  output logic       cmd_valid,
  input  logic       cmd_stall,
  output logic [1:0] action,
  output logic [7:0] angle
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_last;
  logic             advance;
  logic             cmd_sweep;
  scp_pkg::result_t result;

  assign advance   = s1_valid && (!s1_last || !cmd_valid || !cmd_stall);
  assign msg_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!msg_stall) begin
      s1_valid <= msg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_valid && !msg_stall) begin
      s1_byte <= msg_byte;
      s1_last <= last_byte;
    end
  end

  scp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .data    (s1_byte),
    .last    (s1_last),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (advance && s1_last) begin
      cmd_valid <= 1'b1;
    end else if (!cmd_stall) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      action <= 2'(result.action);
      angle  <= result.angle;
    end
  end

  assign cmd_sweep = cmd_valid && (action == 2'(scp_pkg::ACT_SWEEP));

  `SCP_ASSERT_NOW(a_angle_range, cmd_valid, angle <= scp_pkg::ANGLE_MAX)
  `SCP_ASSERT_NOW(a_sweep_center, cmd_sweep, angle == scp_pkg::ANGLE_CENTER)
  `SCP_ASSERT_NEXT(a_drain, cmd_valid && !cmd_stall && !(advance && s1_last), !cmd_valid)

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       msg_valid = 1'b0;
  logic       msg_stall;
  logic [7:0] msg_byte = 8'd0;
  logic       last_byte = 1'b0;
  logic       cmd_valid;
  logic       cmd_stall = 1'b0;
  logic [1:0] action;
  logic [7:0] angle;

  servo_command_parser dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg_byte  (msg_byte),
    .last_byte (last_byte),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .action    (action),
    .angle     (angle)
  );

  typedef struct packed {
    logic [4:0]       len;
    logic [127:0]     text;
    logic             pinned;
    scp_pkg::action_t act;
    logic [7:0]       ang;
  } probe_t;

  probe_t              probes[$];
  scp_pkg::result_t    pending_cmds[$];
  logic [7:0]          msg_bytes[$];
  scp_pkg::result_t    got_cmd;
  logic [7:0]          servo_angle;
  scp_pkg::msg_state_t msg;
  string               center_word = "CENTER";
  string               sweep_word = "SWEEP";
  int                  errors = 0;
  int                  random_bytes = 0;
  bit                  quiet = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  function automatic bit is_numeral(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return (b == scp_pkg::BYTE_CR) || (b == scp_pkg::BYTE_LF) ||
           (b == scp_pkg::BYTE_SPACE);
  endfunction

  // Parser state update for one accepted byte; queues the command on the last one.
  task automatic decode_byte(input logic [7:0] b, input bit fin);
    logic [7:0]       up;
    int               n;
    scp_pkg::result_t cmd;
    if (msg.byte_count == 3'd0) msg.first_value = b;
    if (msg.byte_count != scp_pkg::COUNT_SAT) msg.byte_count = msg.byte_count + 3'd1;
    if (is_blank(b)) begin
      msg.trailing_space = 1'b1;
    end else if (msg.trailing_space) begin
      msg.center_alive = 1'b0;
      msg.sweep_alive  = 1'b0;
      msg.digits_alive = 1'b0;
    end else begin
      up = b;
      if ((b >= "a") && (b <= "z")) up = b - 8'd32;
      if (msg.center_alive && (msg.center_progress < scp_pkg::CENTER_LEN) &&
          (up == center_word[msg.center_progress]))
        msg.center_progress = msg.center_progress + 3'd1;
      else
        msg.center_alive = 1'b0;
      if (msg.sweep_alive && (msg.sweep_progress < scp_pkg::SWEEP_LEN) &&
          (up == sweep_word[msg.sweep_progress]))
        msg.sweep_progress = msg.sweep_progress + 3'd1;
      else
        msg.sweep_alive = 1'b0;
      if (msg.digits_alive && is_numeral(b)) begin
        n = int'(msg.number_value) * 10 + int'(b - 8'd48);
        msg.number_value = (n > 255) ? scp_pkg::NUMBER_SAT : n[7:0];
        msg.digit_count = 1'b1;
      end else begin
        msg.digits_alive = 1'b0;
      end
    end
    if (fin) begin
      if ((msg.byte_count == 3'd1) && (msg.first_value <= scp_pkg::ANGLE_MAX) &&
          !is_numeral(msg.first_value)) begin
        cmd.action  = scp_pkg::ACT_MOVE;
        servo_angle = msg.first_value;
      end else if (msg.center_alive && (msg.center_progress == scp_pkg::CENTER_LEN)) begin
        cmd.action  = scp_pkg::ACT_MOVE;
        servo_angle = scp_pkg::ANGLE_CENTER;
      end else if (msg.sweep_alive && (msg.sweep_progress == scp_pkg::SWEEP_LEN)) begin
        cmd.action  = scp_pkg::ACT_SWEEP;
        servo_angle = scp_pkg::ANGLE_CENTER;
      end else if (msg.digits_alive && msg.digit_count) begin
        cmd.action  = scp_pkg::ACT_MOVE;
        servo_angle = (msg.number_value > scp_pkg::ANGLE_MAX) ?
                      scp_pkg::ANGLE_MAX : msg.number_value;
      end else begin
        cmd.action = scp_pkg::ACT_UNKNOWN;
      end
      cmd.angle = servo_angle;
      pending_cmds.push_back(cmd);
      msg = scp_pkg::MSG_CLEAR;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit fin);
    int gap;
    gap = 0;
    if (!quiet)
      while ($urandom_range(99) < 24) gap++;
    if (gap > 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg_byte  <= b;
    last_byte <= fin;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    decode_byte(b, fin);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++)
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  task automatic push_letters(input string w);
    logic [7:0] c;
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if ((c >= "A") && (c <= "Z") && $urandom_range(1)) c = c + 8'd32;
      msg_bytes.push_back(c);
    end
  endtask

  task automatic push_blanks(input int most);
    logic [7:0] ws[3];
    ws[0] = scp_pkg::BYTE_CR;
    ws[1] = scp_pkg::BYTE_LF;
    ws[2] = scp_pkg::BYTE_SPACE;
    repeat ($urandom_range(most)) msg_bytes.push_back(ws[$urandom_range(2)]);
  endtask

  task automatic push_number();
    int digits;
    digits = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    repeat (digits) msg_bytes.push_back(8'd48 + 8'($urandom_range(9)));
  endtask

  task automatic build_random_message();
    int k;
    int pos;
    msg_bytes.delete();
    k = $urandom_range(99);
    if (k < 22) begin
      push_letters("CENTER");
      push_blanks($urandom_range(3) == 0 ? 3 : 0);
    end else if (k < 40) begin
      push_letters("SWEEP");
      push_blanks($urandom_range(3) == 0 ? 3 : 0);
    end else if (k < 65) begin
      push_number();
      push_blanks($urandom_range(3) == 0 ? 2 : 0);
    end else if (k < 75) begin
      msg_bytes.push_back(8'($urandom_range(255)));
    end else if (k < 88) begin
      case ($urandom_range(2))
        0:       push_letters("CENTER");
        1:       push_letters("SWEEP");
        default: push_number();
      endcase
      pos = $urandom_range(msg_bytes.size() - 1);
      case ($urandom_range(3))
        0: if (msg_bytes.size() > 1) msg_bytes.delete(msg_bytes.size() - 1);
        1: msg_bytes[pos] = scp_pkg::BYTE_SPACE;
        2: msg_bytes[pos] = 8'($urandom_range(255));
        default: push_letters("E");
      endcase
    end else begin
      repeat ($urandom_range(1, 9)) msg_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic add_probe(input logic [4:0] len, input logic [127:0] text,
                           input logic pinned, input scp_pkg::action_t act,
                           input logic [7:0] ang);
    probe_t p;
    p.len    = len;
    p.text   = text;
    p.pinned = pinned;
    p.act    = act;
    p.ang    = ang;
    probes.push_back(p);
  endtask

  always @(posedge clk) begin
    if (rst || quiet) cmd_stall <= 1'b0;
    else cmd_stall <= ($urandom_range(99) < 24);
  end

  // Result-side checking on each accepted transfer.
  always @(posedge clk) begin
    if (!rst && cmd_valid && !cmd_stall) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected command action=%0d angle=%0d", action, angle));
      end else begin
        got_cmd = pending_cmds.pop_front();
        if (action !== got_cmd.action)
          report_mismatch($sformatf("action got %0d want %0d", action, got_cmd.action));
        if (angle !== got_cmd.angle)
          report_mismatch($sformatf("angle got %0d want %0d", angle, got_cmd.angle));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    servo_angle = scp_pkg::ANGLE_CENTER;
    msg = scp_pkg::MSG_CLEAR;

    add_probe(6,  "CENTER",       1, scp_pkg::ACT_MOVE,    8'd90);
    add_probe(1,  8'd0,           1, scp_pkg::ACT_MOVE,    8'd0);
    add_probe(1,  8'd180,         1, scp_pkg::ACT_MOVE,    8'd180);
    add_probe(1,  8'd181,         1, scp_pkg::ACT_UNKNOWN, 8'd180);
    add_probe(1,  8'd255,         1, scp_pkg::ACT_UNKNOWN, 8'd180);
    add_probe(1,  "7",            1, scp_pkg::ACT_MOVE,    8'd7);
    add_probe(1,  " ",            1, scp_pkg::ACT_MOVE,    8'd32);
    add_probe(1,  "\015",         1, scp_pkg::ACT_MOVE,    8'd13);
    add_probe(5,  "sweep",        1, scp_pkg::ACT_SWEEP,   8'd90);
    add_probe(8,  "Center\015\n", 1, scp_pkg::ACT_MOVE,    8'd90);
    add_probe(6,  "SWEEP ",       1, scp_pkg::ACT_SWEEP,   8'd90);
    add_probe(2,  "  ",           1, scp_pkg::ACT_UNKNOWN, 8'd90);
    add_probe(4,  "12 3",         1, scp_pkg::ACT_UNKNOWN, 8'd90);
    add_probe(3,  "999",          1, scp_pkg::ACT_MOVE,    8'd180);
    add_probe(10, "0000000123",   1, scp_pkg::ACT_MOVE,    8'd123);
    add_probe(4,  "170\n",        1, scp_pkg::ACT_MOVE,    8'd170);
    add_probe(7,  "CENTERX",      1, scp_pkg::ACT_UNKNOWN, 8'd170);
    add_probe(4,  "SWEE",         1, scp_pkg::ACT_UNKNOWN, 8'd170);
    add_probe(1,  "A",            1, scp_pkg::ACT_MOVE,    8'd65);
    add_probe(1,  "0",            1, scp_pkg::ACT_MOVE,    8'd0);
    add_probe(3,  "255",          1, scp_pkg::ACT_MOVE,    8'd180);
    add_probe(6,  "CeNtEr",       1, scp_pkg::ACT_MOVE,    8'd90);
    add_probe(3,  "x90",          1, scp_pkg::ACT_UNKNOWN, 8'd90);
    add_probe(3,  "\n90",         1, scp_pkg::ACT_UNKNOWN, 8'd90);
    add_probe(9,  "swEEp \015\nX", 0, scp_pkg::ACT_UNKNOWN, 8'd0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[r]) begin
      msg_bytes.delete();
      for (int i = 0; i < probes[r].len; i++)
        msg_bytes.push_back(probes[r].text[8 * (probes[r].len - 1 - i) +: 8]);
      send_message();
      if (probes[r].pinned) begin
        pending_cmds[pending_cmds.size() - 1].action = probes[r].act;
        pending_cmds[pending_cmds.size() - 1].angle  = probes[r].ang;
      end
    end

    // hold off until the output side has drained
    msg_valid <= 1'b0;
    wait (pending_cmds.size() == 0);
    @(posedge clk);

    while (random_bytes < 1100) begin
      quiet = (random_bytes >= 400) && (random_bytes < 650);
      build_random_message();
      random_bytes += msg_bytes.size();
      send_message();
    end
    quiet = 1'b0;

    msg_valid <= 1'b0;
    wait (pending_cmds.size() == 0);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
